// ===== rtl/nls_pkg.sv =====
// ----------------------------------------------------------------------------
// nls_pkg
// Types, character codes and character-class helpers for the numeric
// literal scanner.
// ----------------------------------------------------------------------------
package nls_pkg;

  typedef enum logic [3:0] {
    PhIdle     = 4'd0,
    PhZero     = 4'd1,
    PhInt      = 4'd2,
    PhHexDot   = 4'd3,
    PhFrac     = 4'd4,
    PhExpSign  = 4'd5,
    PhExpFirst = 4'd6,
    PhExpDig   = 4'd7,
    PhSuffix   = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    RxDec = 2'd0,
    RxHex = 2'd1,
    RxBin = 2'd2,
    RxOct = 2'd3
  } radix_e;

  typedef enum logic [1:0] {
    ErrNone       = 2'd0,
    ErrTrailSep   = 2'd1,
    ErrDoubleSep  = 2'd2,
    ErrNoExpDigit = 2'd3
  } err_e;

  // character codes (letters in lower case, compared after folding)
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChE     = 8'h65;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] ChL     = 8'h6C;
  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] CaseBit = 8'h20;

  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
  } in_item_t;

  typedef struct packed {
    logic       done_res;
    logic       kind;
    logic [1:0] radix;
    logic [7:0] lit_length;
    logic [1:0] returned_chars;
    logic [1:0] error_code;
  } out_item_t;

  // Setting bit 5 folds upper-case letters onto lower case; the only other
  // codes that land on a letter this way are the letter itself.
  function automatic logic [7:0] fold(input logic [7:0] c);
    return c | CaseBit;
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((fold(c) >= ChA) && (fold(c) <= ChF));
  endfunction

  function automatic logic is_radix_digit(input logic [7:0] c, input radix_e r);
    logic res;
    case (r)
      RxBin:   res = (c == ChZero) || (c == ChOne);
      RxOct:   res = (c >= ChZero) && (c <= ChSeven);
      RxHex:   res = is_hex(c);
      default: res = is_dec(c);
    endcase
    return res;
  endfunction

  function automatic logic is_float_suffix(input logic [7:0] c);
    return (fold(c) == ChF) || (fold(c) == ChD);
  endfunction

  function automatic logic is_suffix(input logic [7:0] c);
    return (fold(c) == ChU) || (fold(c) == ChL) || is_float_suffix(c);
  endfunction

endpackage

// ===== rtl/nls_if.sv =====
// ----------------------------------------------------------------------------
// nls_in_if / nls_out_if
// Valid/ready channels carrying scanner input and result items.
// ----------------------------------------------------------------------------
interface nls_in_if;
  logic              valid;
  logic              ready;
  nls_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface nls_out_if;
  logic               valid;
  logic               ready;
  nls_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/numeric_literal_scanner_top.sv =====
// ----------------------------------------------------------------------------
// numeric_literal_scanner_top
// Recognizes one numeric literal from a character stream, one char per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one source character per item (ch, at_end). The first item
//   of a literal is its first decimal digit. out_o returns exactly one result
//   item per input item; done_res marks the item that ended the literal and
//   then kind, radix, lit_length, returned_chars and error_code are final.
//   returned_chars tells how many recent characters must be fed again.
//   The result is held in the output register from the cycle after the
//   item is accepted. Throughput: one item per cycle unless out_o stalls;
//   the scanner state and the result register both update in the accepting
//   cycle, so the next character is decided against the new state right away.
//   Stall: in_i.ready drops only while the result register is full and
//   out_o.ready is low; no item is lost or repeated.
//   Reset: scanner returns to idle (expects a first digit), output empty.
//   After each done result the scanner returns to idle by itself.
// ----------------------------------------------------------------------------
module numeric_literal_scanner_top #(
  parameter int MAX_LEN = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  nls_in_if.sink           in_i,
  nls_out_if.source        out_o
);
  import nls_pkg::*;

  localparam int CntW = $clog2(MAX_LEN + 1);
  localparam int LenW = (CntW > 8) ? CntW : 8;

  // scanner state
  phase_e          phase_q, phase_d;
  radix_e          radix_q, radix_d;
  logic            psep_q, psep_d;
  logic            seen_q, seen_d;
  logic            flt_q, flt_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // result register
  logic            out_valid_q;
  out_item_t       res_q, res_d;

  logic            in_acc;
  logic [7:0]      ch;
  logic            live;
  logic            run_int, run_frac, run_exs, run_exf, run_sfx;
  logic [1:0]      inc;
  logic [CntW-1:0] cnt_base;
  logic [CntW:0]   cnt_sum;
  logic [CntW-1:0] cnt_new;
  logic [LenW-1:0] cnt_ext;
  logic            done;
  logic [1:0]      ret;
  err_e            err;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign ch         = in_i.payload.ch;
  assign live       = !in_i.payload.at_end;

  always_comb begin
    phase_d  = phase_q;
    radix_d  = radix_q;
    psep_d   = psep_q;
    seen_d   = seen_q;
    flt_d    = flt_q;
    cnt_base = cnt_q;
    inc      = 2'd0;
    done     = 1'b0;
    ret      = 2'd0;
    err      = ErrNone;
    run_int  = 1'b0;
    run_frac = 1'b0;
    run_exs  = 1'b0;
    run_exf  = 1'b0;
    run_sfx  = 1'b0;

    case (phase_q)
      PhZero: begin
        if (live && fold(ch) == ChX) begin
          radix_d = RxHex;
          inc     = inc + 2'd1;
          phase_d = PhInt;
        end else if (live && fold(ch) == ChB) begin
          radix_d = RxBin;
          inc     = inc + 2'd1;
          phase_d = PhInt;
        end else if (live && is_dec(ch)) begin
          radix_d = RxOct;
          phase_d = PhInt;
          run_int = 1'b1;
        end else begin
          radix_d = RxDec;
          seen_d  = 1'b1;
          phase_d = PhInt;
          run_int = 1'b1;
        end
      end
      PhInt: run_int = 1'b1;
      PhHexDot: begin
        if (live && is_hex(ch)) begin
          // dot is kept, then the digit is taken as the first fraction digit
          flt_d    = 1'b1;
          inc      = inc + 2'd1;
          phase_d  = PhFrac;
          run_frac = 1'b1;
        end else begin
          done = 1'b1;
          ret  = live ? 2'd2 : 2'd1;
        end
      end
      PhFrac: run_frac = 1'b1;
      PhExpSign: begin
        if (live && (ch == ChPlus || ch == ChMinus)) begin
          inc     = inc + 2'd1;
          phase_d = PhExpFirst;
        end else begin
          run_exf = 1'b1;
        end
      end
      PhExpFirst: run_exf = 1'b1;
      PhExpDig: begin
        if (live && is_dec(ch)) begin
          inc = inc + 2'd1;
        end else begin
          run_sfx = 1'b1;
        end
      end
      PhSuffix: run_sfx = 1'b1;
      default: begin
        // idle and unused codes: start a new literal
        radix_d  = RxDec;
        psep_d   = 1'b0;
        seen_d   = 1'b0;
        flt_d    = 1'b0;
        cnt_base = '0;
        phase_d  = PhIdle;
        if (live && is_dec(ch)) begin
          cnt_base = CntW'(1);
          if (ch == ChZero) begin
            phase_d = PhZero;
          end else begin
            seen_d  = 1'b1;
            phase_d = PhInt;
          end
        end else begin
          done = 1'b1;
          ret  = {1'b0, live};
        end
      end
    endcase

    if (run_int) begin
      if (live && ch == ChApos && seen_d && !psep_d) begin
        psep_d = 1'b1;
        inc    = inc + 2'd1;
      end else if (live && is_radix_digit(ch, radix_d)) begin
        seen_d = 1'b1;
        psep_d = 1'b0;
        inc    = inc + 2'd1;
      end else if (psep_d) begin
        done = 1'b1;
        ret  = {1'b0, live};
        err  = ErrTrailSep;
      end else if (live && ch == ChDot && radix_d == RxDec) begin
        flt_d   = 1'b1;
        inc     = inc + 2'd1;
        phase_d = PhFrac;
      end else if (live && ch == ChDot && radix_d == RxHex) begin
        phase_d = PhHexDot;
      end else begin
        run_exs = 1'b1;
      end
    end

    if (run_frac) begin
      if (live && ch == ChApos) begin
        if (psep_d) begin
          done = 1'b1;
          ret  = 2'd1;
          err  = ErrDoubleSep;
        end else begin
          psep_d = 1'b1;
          inc    = inc + 2'd1;
        end
      end else if (live && is_radix_digit(ch, radix_d)) begin
        psep_d = 1'b0;
        inc    = inc + 2'd1;
      end else begin
        run_exs = 1'b1;
      end
    end

    if (run_exs) begin
      if (live && (radix_d == RxDec || radix_d == RxHex) &&
          fold(ch) == ((radix_d == RxHex) ? ChP : ChE)) begin
        flt_d   = 1'b1;
        inc     = inc + 2'd1;
        phase_d = PhExpSign;
      end else begin
        run_sfx = 1'b1;
      end
    end

    if (run_exf) begin
      if (live && is_dec(ch)) begin
        inc     = inc + 2'd1;
        phase_d = PhExpDig;
      end else begin
        done = 1'b1;
        ret  = {1'b0, live};
        err  = ErrNoExpDigit;
      end
    end

    if (run_sfx) begin
      if (live && is_suffix(ch)) begin
        if (is_float_suffix(ch)) begin
          flt_d = 1'b1;
        end
        inc     = inc + 2'd1;
        phase_d = PhSuffix;
      end else begin
        done = 1'b1;
        ret  = {1'b0, live};
      end
    end
  end

  // count saturates at MAX_LEN; at most two characters per item
  assign cnt_sum = {1'b0, cnt_base} + (CntW + 1)'(inc);
  assign cnt_new = (cnt_sum > (CntW + 1)'(MAX_LEN)) ? CntW'(MAX_LEN) : cnt_sum[CntW-1:0];
  assign cnt_ext = LenW'(cnt_new);
  assign cnt_d   = done ? '0 : cnt_new;

  always_comb begin
    res_d.done_res       = done;
    res_d.kind           = flt_d;
    res_d.radix          = radix_d;
    res_d.lit_length     = (cnt_ext > LenW'(255)) ? 8'hFF : cnt_ext[7:0];
    res_d.returned_chars = ret;
    res_d.error_code     = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      radix_q <= RxDec;
      psep_q  <= 1'b0;
      seen_q  <= 1'b0;
      flt_q   <= 1'b0;
      cnt_q   <= '0;
    end else if (in_acc) begin
      if (done) begin
        phase_q <= PhIdle;
        radix_q <= RxDec;
        psep_q  <= 1'b0;
        seen_q  <= 1'b0;
        flt_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        radix_q <= radix_d;
        psep_q  <= psep_d;
        seen_q  <= seen_d;
        flt_q   <= flt_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = res_q;

`ifndef SYNTHESIS
  // a finished literal leaves the scanner idle with an empty count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && done |=> phase_q == PhIdle && cnt_q == '0)
    else $error("scanner not idle after finished literal");

  // end of source always terminates the literal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !live |=> out_o.valid && out_o.payload.done_res)
    else $error("end of source did not finish literal");

  // errors and returned characters only come with a finished literal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.payload.error_code != ErrNone ||
                    out_o.payload.returned_chars != 2'd0) |-> out_o.payload.done_res)
    else $error("error or returned chars on unfinished item");
`endif

endmodule
